// ===== hw/rtl/qoi_pkg.sv =====
// ----------------------------------------------------------------------------
// qoi_pkg
// Shared types and opcode constants for the pixel stream encoder.
// ----------------------------------------------------------------------------
package qoi_pkg;

  localparam logic [7:0] OP_INDEX = 8'h00;
  localparam logic [7:0] OP_DIFF  = 8'h40;
  localparam logic [7:0] OP_LUMA  = 8'h80;
  localparam logic [7:0] OP_RUN   = 8'hc0;
  localparam logic [7:0] OP_RGB   = 8'hfe;
  localparam logic [7:0] OP_RGBA  = 8'hff;
  localparam int unsigned RUN_LIMIT = 62;
  localparam int unsigned SLOTS = 64;
  localparam int unsigned SLOT_W = $clog2(SLOTS);
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } pix_t;

  // one classified pixel handed from front to back
  typedef struct packed {
    pix_t px;
    logic last;
  } job_t;

endpackage

// ===== hw/rtl/qoi_if.sv =====
// ----------------------------------------------------------------------------
// qoi_in_if / qoi_out_if
// Valid/ready channels for pixels in and stream bytes out.
// ----------------------------------------------------------------------------
interface qoi_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] blue_premul;
  logic [7:0] green_premul;
  logic [7:0] red_premul;
  logic [7:0] alpha_in;
  logic       final_pixel;
  modport source (output valid, blue_premul, green_premul, red_premul, alpha_in,
                  final_pixel, input ready);
  modport sink (input valid, blue_premul, green_premul, red_premul, alpha_in,
                final_pixel, output ready);
endinterface

interface qoi_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       end_of_burst;
  modport source (output valid, out_byte, end_of_burst, input ready);
  modport sink (input valid, out_byte, end_of_burst, output ready);
endinterface

// ===== hw/rtl/qoi_unpremul.sv =====
// ----------------------------------------------------------------------------
// qoi_unpremul
// Front part: undoes premultiplication with a shared restoring divider,
// one quotient bit per cycle, and pushes the pixel into the job queue.
// ----------------------------------------------------------------------------
module qoi_unpremul (
  input  logic             clk,
  input  logic             rst_n,
  qoi_in_if.sink           in_ch,
  output logic             job_valid,
  input  logic             job_ready,
  output qoi_pkg::job_t    job
);
  import qoi_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_DONE} state_t;

  state_t      state_r;
  logic [1:0]  chan_r;
  logic [3:0]  bit_r;
  logic [15:0] num_r;
  logic [15:0] quo_r;
  logic [8:0]  rem_r;
  logic [7:0]  c_r [3];
  logic [7:0]  res_r [3];
  logic [7:0]  a_r;
  logic        last_r;
  logic [8:0]  trial;
  logic        fits;

  assign in_ch.ready = (state_r == S_IDLE);
  assign job_valid   = (state_r == S_DONE);
  assign job         = '{px: '{r: res_r[2], g: res_r[1], b: res_r[0], a: a_r},
                         last: last_r};

  // restoring step: shift in next numerator bit, subtract if it fits
  always_comb begin
    trial = {rem_r[7:0], num_r[15]};
    fits  = (trial >= {1'b0, a_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            c_r[0] <= in_ch.blue_premul;
            c_r[1] <= in_ch.green_premul;
            c_r[2] <= in_ch.red_premul;
            a_r    <= in_ch.alpha_in;
            last_r <= in_ch.final_pixel;
            if (in_ch.alpha_in == 8'd0) begin
              res_r[0] <= in_ch.blue_premul;
              res_r[1] <= in_ch.green_premul;
              res_r[2] <= in_ch.red_premul;
              state_r  <= S_DONE;
            end else begin
              chan_r  <= 2'd0;
              bit_r   <= 4'd0;
              num_r   <= {in_ch.blue_premul, 8'd0} - {8'd0, in_ch.blue_premul};
              rem_r   <= 9'd0;
              quo_r   <= 16'd0;
              state_r <= S_DIV;
            end
          end
        end
        S_DIV: begin
          rem_r <= fits ? trial - {1'b0, a_r} : trial;
          quo_r <= {quo_r[14:0], fits};
          num_r <= {num_r[14:0], 1'b0};
          bit_r <= bit_r + 4'd1;
          if (bit_r == 4'd15) begin
            res_r[chan_r] <= {quo_r[6:0], fits};
            if (chan_r == 2'd2) begin
              state_r <= S_DONE;
            end else begin
              chan_r <= chan_r + 2'd1;
              num_r  <= {c_r[chan_r + 2'd1], 8'd0} - {8'd0, c_r[chan_r + 2'd1]};
              rem_r  <= 9'd0;
              quo_r  <= 16'd0;
            end
          end
        end
        S_DONE: begin
          if (job_ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== hw/rtl/qoi_job_queue.sv =====
// ----------------------------------------------------------------------------
// qoi_job_queue
// Small queue of classified pixels between front and back parts.
// ----------------------------------------------------------------------------
module qoi_job_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  qoi_pkg::job_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output qoi_pkg::job_t rd_data
);
  import qoi_pkg::*;

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);

  job_t          mem_r [QUEUE_DEPTH];
  logic [PW-1:0] wp_r;
  logic [PW-1:0] rp_r;
  logic [PW:0]   cnt_r;
  logic          push;
  logic          pop;

  assign wr_ready = (cnt_r != (PW+1)'(QUEUE_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (pop)  rp_r <= (rp_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(pop);
    end
  end
endmodule

// ===== hw/rtl/qoi_coder.sv =====
// ----------------------------------------------------------------------------
// qoi_coder
// Back part: codes one pixel against the previous one and the color
// index, then sends the opcode bytes one per cycle while out_ch is ready.
// ----------------------------------------------------------------------------
module qoi_coder (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          job_valid,
  output logic          job_ready,
  input  qoi_pkg::job_t job,
  qoi_out_if.source     out_ch
);
  import qoi_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_LOOK, S_EMIT, S_CLEAR} state_t;

  state_t            state_r;
  pix_t              idx_r [SLOTS];
  logic [SLOTS-1:0]  vld_r;
  pix_t              prev_r;
  logic [5:0]        run_r;
  job_t              job_r;
  logic [SLOT_W-1:0] slot_r;
  pix_t              hit_px_r;
  logic [7:0]        buf_r [14];
  logic [3:0]        len_r;
  logic [3:0]        pos_r;

  pix_t              px;
  pix_t              idx_px;
  logic [7:0]        dr, dg, db, dgr, dgb;
  logic              small_d, luma_ok;
  logic [7:0]        b [14];
  logic [3:0]        n;
  logic              same;

  function automatic logic [SLOT_W-1:0] slot_of(pix_t p);
    logic [9:0] s;
    s = 10'(p.r) * 10'd3 + 10'(p.g) * 10'd5 + 10'(p.b) * 10'd7 + 10'(p.a) * 10'd11;
    return s[SLOT_W-1:0];
  endfunction

  assign px = job_r.px;
  assign idx_px = vld_r[slot_r] ? hit_px_r : '0;

  assign job_ready       = (state_r == S_IDLE);
  assign out_ch.valid    = (state_r == S_EMIT);
  assign out_ch.out_byte = buf_r[pos_r];
  assign out_ch.end_of_burst = (pos_r == len_r - 4'd1);

  // build the byte burst for the looked-up pixel
  always_comb begin
    dr  = px.r - prev_r.r;
    dg  = px.g - prev_r.g;
    db  = px.b - prev_r.b;
    dgr = dr - dg;
    dgb = db - dg;
    small_d = ((dr + 8'd2) < 8'd4) && ((dg + 8'd2) < 8'd4) && ((db + 8'd2) < 8'd4);
    luma_ok = ((dgr + 8'd8) < 8'd16) && ((dgb + 8'd8) < 8'd16)
           && ((dg + 8'd32) < 8'd64);
    same = (px == prev_r);
    for (int i = 0; i < 14; i++) b[i] = 8'h00;
    n = 4'd0;
    if (same) begin
      if (run_r == 6'(RUN_LIMIT - 1) || job_r.last) begin
        b[0] = OP_RUN | {2'b00, run_r};
        n = 4'd1;
      end
    end else begin
      if (run_r != 6'd0) begin
        b[0] = OP_RUN | {2'b00, run_r - 6'd1};
        n = 4'd1;
      end
      if (idx_px == px) begin
        b[n] = OP_INDEX | {2'b00, slot_r};
        n = n + 4'd1;
      end else if (px.a != prev_r.a) begin
        b[n] = OP_RGBA; b[n+4'd1] = px.r; b[n+4'd2] = px.g;
        b[n+4'd3] = px.b; b[n+4'd4] = px.a;
        n = n + 4'd5;
      end else if (small_d) begin
        b[n] = OP_DIFF | {2'b00, dr[1:0] + 2'd2, dg[1:0] + 2'd2, db[1:0] + 2'd2};
        n = n + 4'd1;
      end else if (luma_ok) begin
        b[n] = OP_LUMA | {2'b00, dg[5:0] + 6'd32};
        b[n+4'd1] = {dgr[3:0] + 4'd8, dgb[3:0] + 4'd8};
        n = n + 4'd2;
      end else begin
        b[n] = OP_RGB; b[n+4'd1] = px.r; b[n+4'd2] = px.g; b[n+4'd3] = px.b;
        n = n + 4'd4;
      end
    end
    if (job_r.last) begin
      for (int i = 0; i < 7; i++) b[n + 4'(i)] = 8'h00;
      b[n + 4'd7] = 8'h01;
      n = n + 4'd8;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && job_valid) hit_px_r <= idx_r[slot_of(job.px)];
    if (state_r == S_LOOK && !(px == prev_r) && !(idx_px == px)) idx_r[slot_r] <= px;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      vld_r   <= '0;
      prev_r  <= '{r: 8'd0, g: 8'd0, b: 8'd0, a: 8'd255};
      run_r   <= 6'd0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (job_valid) begin
            job_r   <= job;
            slot_r  <= slot_of(job.px);
            state_r <= S_LOOK;
          end
        end
        S_LOOK: begin
          for (int i = 0; i < 14; i++) buf_r[i] <= b[i];
          len_r  <= n;
          pos_r  <= 4'd0;
          prev_r <= px;
          if (same) begin
            run_r <= (run_r == 6'(RUN_LIMIT - 1) || job_r.last) ? 6'd0 : run_r + 6'd1;
          end else begin
            run_r <= 6'd0;
            if (!(idx_px == px)) vld_r[slot_r] <= 1'b1;
          end
          if (job_r.last) state_r <= S_CLEAR;
          else state_r <= (n == 4'd0) ? S_IDLE : S_EMIT;
        end
        S_CLEAR: begin
          // end of image: back to reset state, then drain the burst
          vld_r   <= '0;
          prev_r  <= '{r: 8'd0, g: 8'd0, b: 8'd0, a: 8'd255};
          run_r   <= 6'd0;
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (out_ch.ready) begin
            pos_r <= pos_r + 4'd1;
            if (pos_r == len_r - 4'd1) state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== hw/rtl/qoi_pixel_stream_encoder.sv =====
// ----------------------------------------------------------------------------
// qoi_pixel_stream_encoder
// Un-premultiplies BGRA pixels and codes them into a QOI byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one premultiplied pixel per transfer, final_pixel on the
//   last pixel of an image. out_ch carries stream bytes, one per transfer,
//   with end_of_burst on the last byte that a pixel causes; pixels inside a
//   run cause no bytes. The header is not written by this block.
//   Flow: the front divides blue, green and red in turn for a pixel with
//   nonzero alpha and passes a zero-alpha pixel through undivided; it takes
//   no new pixel before it has handed off the previous one. The back coder
//   looks up a pixel, clears its state on a last pixel, then sends its
//   bytes, if any, and takes no new pixel before they are all sent. A
//   two-entry queue parts the two so each stalls on its own. A stalled
//   receiver holds the current byte and fills the queue, then
//   back-pressures in_ch. Reset (rst_n low, synchronous) empties the queue,
//   clears the color index and sets the previous pixel to opaque black;
//   the coder clears the index and previous pixel in the same way on each
//   last pixel of an image, before its end marker is sent.
// ----------------------------------------------------------------------------
module qoi_pixel_stream_encoder (
  input  logic       clk,
  input  logic       rst_n,
  qoi_in_if.sink     in_ch,
  qoi_out_if.source  out_ch
);
  import qoi_pkg::*;

  logic f_valid, f_ready, b_valid, b_ready;
  job_t f_job, b_job;

  qoi_unpremul u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
  );

  qoi_job_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_job),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_job)
  );

  qoi_coder u_back (
    .clk(clk), .rst_n(rst_n),
    .job_valid(b_valid), .job_ready(b_ready), .job(b_job), .out_ch(out_ch)
  );
endmodule
